FILE: hw/rtl/assert_macros.svh
// assertion macros used by the txrr_seq rtl module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define TXRR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TXRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/txrr_pkg.sv
// shared types and constants for the transmit descriptor pool
`default_nettype none

package txrr_pkg;

    localparam int SLOT_COUNT_DEF = 4;
    localparam int ADDR_W         = 32;
    localparam int LEN_W          = 16;
    localparam int OFF_W          = 2;

    localparam logic REQ_SUBMIT = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    typedef enum logic [1:0] {
        SLOT_OP_NONE,
        SLOT_OP_CLAIM,
        SLOT_OP_EMIT,
        SLOT_OP_FREE
    } t_slot_op;

    typedef struct packed {
        t_slot_op            op;
        logic [ADDR_W-1:0]   addr;
        logic [LEN_W-1:0]    len;
    } t_slot_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } t_state;

endpackage

`default_nettype wire

FILE: hw/rtl/tx_descriptor_round_robin_engine_core.sv
// top level of the round-robin transmit descriptor pool
//
// channel   direction  handshake                 payload
// request   in         start & !busy             i_req_type, i_buf_addr, i_buf_len
// result    out        o_valid (one-cycle pulse) o_accepted, o_probe_offset,
//                                                o_byte_valid, o_byte_addr, o_tx_active
//
// one request is in flight at a time; busy stays high until its result strobes
// submit: slots are probed from the current one, one per cycle, until one is free or all
// are probed; tick: the result follows the exec step if a byte is sent or transmit is off,
// else the drained slot is freed and the pool is scanned for the next busy slot
// synchronous active-low reset empties every slot; results cannot be stalled
`default_nettype none

module tx_descriptor_round_robin_engine_core #(
    parameter int SLOT_COUNT = txrr_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_req_type,
    input  wire logic [txrr_pkg::ADDR_W-1:0] i_buf_addr,
    input  wire logic [txrr_pkg::LEN_W-1:0]  i_buf_len,
    output logic                             o_valid,
    output logic                             o_accepted,
    output logic [txrr_pkg::OFF_W-1:0]       o_probe_offset,
    output logic                             o_byte_valid,
    output logic [txrr_pkg::ADDR_W-1:0]      o_byte_addr,
    output logic                             o_tx_active
);

    localparam int IDX_W = $clog2(SLOT_COUNT);

    txrr_pkg::t_slot_cmd             w_cmd;
    logic [IDX_W-1:0]                w_wr_idx;
    logic [IDX_W-1:0]                w_cur_idx;
    logic [IDX_W-1:0]                w_probe_idx;
    logic                            w_probe_busy;
    logic [txrr_pkg::ADDR_W-1:0]     w_cur_addr;
    logic [txrr_pkg::LEN_W-1:0]      w_cur_count;

    txrr_seq #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (IDX_W)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_req_type     (i_req_type),
        .i_buf_addr     (i_buf_addr),
        .i_buf_len      (i_buf_len),
        .i_probe_busy   (w_probe_busy),
        .i_cur_addr     (w_cur_addr),
        .i_cur_count    (w_cur_count),
        .o_busy         (busy),
        .o_cmd          (w_cmd),
        .o_wr_idx       (w_wr_idx),
        .o_cur_idx      (w_cur_idx),
        .o_probe_idx    (w_probe_idx),
        .o_valid        (o_valid),
        .o_accepted     (o_accepted),
        .o_probe_offset (o_probe_offset),
        .o_byte_valid   (o_byte_valid),
        .o_byte_addr    (o_byte_addr),
        .o_tx_active    (o_tx_active)
    );

    txrr_slots #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (IDX_W)
    ) u_slots (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_wr_idx     (w_wr_idx),
        .i_cur_idx    (w_cur_idx),
        .i_probe_idx  (w_probe_idx),
        .o_probe_busy (w_probe_busy),
        .o_cur_addr   (w_cur_addr),
        .o_cur_count  (w_cur_count)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/txrr_slots.sv
// descriptor slot storage: busy bits, buffer addresses and byte counts
`default_nettype none

module txrr_slots #(
    parameter int SLOT_COUNT = txrr_pkg::SLOT_COUNT_DEF,
    parameter int IDX_W      = $clog2(SLOT_COUNT)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire txrr_pkg::t_slot_cmd         i_cmd,
    input  wire logic [IDX_W-1:0]            i_wr_idx,
    input  wire logic [IDX_W-1:0]            i_cur_idx,
    input  wire logic [IDX_W-1:0]            i_probe_idx,
    output logic                             o_probe_busy,
    output logic [txrr_pkg::ADDR_W-1:0]      o_cur_addr,
    output logic [txrr_pkg::LEN_W-1:0]       o_cur_count
);

    logic [SLOT_COUNT-1:0]             r_busy;
    logic [txrr_pkg::ADDR_W-1:0]       r_addr  [SLOT_COUNT];
    logic [txrr_pkg::LEN_W-1:0]        r_count [SLOT_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
            for (int k = 0; k < SLOT_COUNT; k++) begin
                r_addr[k]  <= '0;
                r_count[k] <= '0;
            end
        end else begin
            case (i_cmd.op)
                txrr_pkg::SLOT_OP_CLAIM: begin
                    r_busy[i_wr_idx]  <= 1'b1;
                    r_addr[i_wr_idx]  <= i_cmd.addr;
                    r_count[i_wr_idx] <= i_cmd.len;
                end
                txrr_pkg::SLOT_OP_EMIT: begin
                    r_addr[i_wr_idx]  <= r_addr[i_wr_idx] + 1'b1;
                    r_count[i_wr_idx] <= r_count[i_wr_idx] - 1'b1;
                end
                txrr_pkg::SLOT_OP_FREE: begin
                    r_busy[i_wr_idx]  <= 1'b0;
                    r_addr[i_wr_idx]  <= '0;
                    r_count[i_wr_idx] <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_probe_busy = r_busy[i_probe_idx];
    assign o_cur_addr   = r_addr[i_cur_idx];
    assign o_cur_count  = r_count[i_cur_idx];

endmodule

`default_nettype wire

FILE: hw/rtl/txrr_seq.sv
// request sequencer with the shared slot probe
`default_nettype none

`include "assert_macros.svh"

module txrr_seq #(
    parameter int SLOT_COUNT = txrr_pkg::SLOT_COUNT_DEF,
    parameter int IDX_W      = $clog2(SLOT_COUNT)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic                        i_req_type,
    input  wire logic [txrr_pkg::ADDR_W-1:0] i_buf_addr,
    input  wire logic [txrr_pkg::LEN_W-1:0]  i_buf_len,
    input  wire logic                        i_probe_busy,
    input  wire logic [txrr_pkg::ADDR_W-1:0] i_cur_addr,
    input  wire logic [txrr_pkg::LEN_W-1:0]  i_cur_count,
    output logic                             o_busy,
    output txrr_pkg::t_slot_cmd              o_cmd,
    output logic [IDX_W-1:0]                 o_wr_idx,
    output logic [IDX_W-1:0]                 o_cur_idx,
    output logic [IDX_W-1:0]                 o_probe_idx,
    output logic                             o_valid,
    output logic                             o_accepted,
    output logic [txrr_pkg::OFF_W-1:0]       o_probe_offset,
    output logic                             o_byte_valid,
    output logic [txrr_pkg::ADDR_W-1:0]      o_byte_addr,
    output logic                             o_tx_active
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    txrr_pkg::t_state                r_state, n_state;
    logic                            r_req, n_req;
    logic [txrr_pkg::ADDR_W-1:0]     r_addr, n_addr;
    logic [txrr_pkg::LEN_W-1:0]      r_len, n_len;
    logic [IDX_W-1:0]                r_pos, n_pos;
    logic [IDX_W-1:0]                r_k, n_k;
    logic [IDX_W-1:0]                r_cur, n_cur;
    logic                            r_txon, n_txon;
    logic                            r_valid, n_valid;
    logic                            r_acc, n_acc;
    logic [txrr_pkg::OFF_W-1:0]      r_off, n_off;
    logic                            r_bvalid, n_bvalid;
    logic [txrr_pkg::ADDR_W-1:0]     r_baddr, n_baddr;

    logic                            w_last;
    logic                            w_hit;
    logic [IDX_W-1:0]                w_pos_inc;
    logic [IDX_W-1:0]                w_cur_inc;

    // shared probe unit: one slot per cycle, wrapping index
    assign w_last    = (r_k == LAST_IDX);
    assign w_pos_inc = (r_pos == LAST_IDX) ? '0 : r_pos + 1'b1;
    assign w_cur_inc = (r_cur == LAST_IDX) ? '0 : r_cur + 1'b1;
    // submit looks for a free slot, tick looks for a busy one
    assign w_hit     = (r_req == txrr_pkg::REQ_SUBMIT) ? !i_probe_busy : i_probe_busy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            txrr_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = (i_req_type == txrr_pkg::REQ_SUBMIT) ?
                              txrr_pkg::ST_SCAN : txrr_pkg::ST_EXEC;
                end
            end
            txrr_pkg::ST_EXEC: begin
                if (r_txon && (i_cur_count == '0)) begin
                    n_state = txrr_pkg::ST_SCAN;
                end else begin
                    n_state = txrr_pkg::ST_IDLE;
                end
            end
            txrr_pkg::ST_SCAN: begin
                if (w_hit || w_last) begin
                    n_state = txrr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = txrr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_req    = r_req;
        n_addr   = r_addr;
        n_len    = r_len;
        n_pos    = r_pos;
        n_k      = r_k;
        n_cur    = r_cur;
        n_txon   = r_txon;
        n_valid  = 1'b0;
        n_acc    = r_acc;
        n_off    = r_off;
        n_bvalid = r_bvalid;
        n_baddr  = r_baddr;
        o_cmd.op   = txrr_pkg::SLOT_OP_NONE;
        o_cmd.addr = r_addr;
        o_cmd.len  = r_len;
        o_wr_idx   = r_cur;
        case (r_state)
            txrr_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_req  = i_req_type;
                    n_addr = i_buf_addr;
                    n_len  = i_buf_len;
                    n_pos  = r_cur;
                    n_k    = '0;
                end
            end
            txrr_pkg::ST_EXEC: begin
                if (!r_txon) begin
                    n_valid  = 1'b1;
                    n_acc    = 1'b0;
                    n_off    = '0;
                    n_bvalid = 1'b0;
                    n_baddr  = '0;
                end else if (i_cur_count != '0) begin
                    o_cmd.op = txrr_pkg::SLOT_OP_EMIT;
                    n_valid  = 1'b1;
                    n_acc    = 1'b0;
                    n_off    = '0;
                    n_bvalid = 1'b1;
                    n_baddr  = i_cur_addr;
                end else begin
                    // slot drained: free it and hunt from the next one
                    o_cmd.op = txrr_pkg::SLOT_OP_FREE;
                    n_cur    = w_cur_inc;
                    n_pos    = w_cur_inc;
                    n_k      = '0;
                end
            end
            txrr_pkg::ST_SCAN: begin
                if (w_hit || w_last) begin
                    n_valid  = 1'b1;
                    n_acc    = 1'b0;
                    n_off    = '0;
                    n_bvalid = 1'b0;
                    n_baddr  = '0;
                end
                if (r_req == txrr_pkg::REQ_SUBMIT) begin
                    if (w_hit) begin
                        o_cmd.op = txrr_pkg::SLOT_OP_CLAIM;
                        o_wr_idx = r_pos;
                        n_txon   = 1'b1;
                        n_acc    = 1'b1;
                        n_off    = txrr_pkg::OFF_W'(r_k);
                    end
                end else begin
                    if (w_hit) begin
                        n_cur = r_pos;
                    end else if (w_last) begin
                        n_txon = 1'b0;
                    end
                end
                if (!w_hit && !w_last) begin
                    n_pos = w_pos_inc;
                    n_k   = r_k + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= txrr_pkg::ST_IDLE;
            r_cur   <= '0;
            r_txon  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_txon  <= n_txon;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_addr   <= n_addr;
        r_len    <= n_len;
        r_pos    <= n_pos;
        r_k      <= n_k;
        r_acc    <= n_acc;
        r_off    <= n_off;
        r_bvalid <= n_bvalid;
        r_baddr  <= n_baddr;
    end

    assign o_busy         = (r_state != txrr_pkg::ST_IDLE);
    assign o_cur_idx      = r_cur;
    assign o_probe_idx    = r_pos;
    assign o_valid        = r_valid;
    assign o_accepted     = r_acc;
    assign o_probe_offset = r_off;
    assign o_byte_valid   = r_bvalid;
    assign o_byte_addr    = r_baddr;
    assign o_tx_active    = r_txon;

    `TXRR_ASSERT_NOW(a_strobe_idle, i_clk, i_rst_n, r_valid, r_state == txrr_pkg::ST_IDLE, "result strobe while sequencer busy")
    `TXRR_ASSERT_NEXT(a_strobe_pulse, i_clk, i_rst_n, r_valid, !r_valid, "result strobe longer than one cycle")
    `TXRR_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy, "accepted request did not start work")
    `TXRR_ASSERT_NOW(a_acc_txon, i_clk, i_rst_n, r_valid && r_acc, r_txon && !r_bvalid, "accepted submit without transmit enabled")
    `TXRR_ASSERT_NOW(a_byte_txon, i_clk, i_rst_n, r_valid && r_bvalid, r_txon, "byte emitted while transmit off")

endmodule

`default_nettype wire
